### hw/rtl/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// dnsp_pkg
// shared types and constants of the dns response a-record parser
// ----------------------------------------------------------------------------
package dnsp_pkg;

   // position in the packet walk
   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_QLEN    = 4'd1,
      PH_QLABEL  = 4'd2,
      PH_QTAIL   = 4'd3,
      PH_ALEN    = 4'd4,
      PH_ALABEL  = 4'd5,
      PH_APTR    = 4'd6,
      PH_AFIXED  = 4'd7,
      PH_ADDR    = 4'd8,
      PH_ASKIP   = 4'd9,
      PH_DONE    = 4'd10
   } parse_phase_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_FOUND   = 3'd0,
      ST_NOADDR  = 3'd1,
      ST_SHORT   = 3'd2,
      ST_NOTRESP = 3'd3,
      ST_QCOUNT  = 3'd4,
      ST_BADNAME = 3'd5,
      ST_BADTC   = 3'd6
   } status_type;

   // byte positions inside fixed-size fields
   localparam logic [3:0] HDR_TXN_LO    = 4'd1;
   localparam logic [3:0] HDR_FLAGS_LO  = 4'd3;
   localparam logic [3:0] HDR_QDCNT_LO  = 4'd5;
   localparam logic [3:0] HDR_ANCNT_LO  = 4'd7;
   localparam logic [3:0] HDR_LAST      = 4'd11;
   localparam logic [3:0] QTAIL_TYPE_LO = 4'd1;
   localparam logic [3:0] QTAIL_LAST    = 4'd3;
   localparam logic [3:0] AFIX_TYPE_LO  = 4'd1;
   localparam logic [3:0] AFIX_TTL_FIRST = 4'd4;
   localparam logic [3:0] AFIX_TTL_LAST = 4'd7;
   localparam logic [3:0] AFIX_LAST     = 4'd9;
   localparam logic [3:0] ADDR_LAST     = 4'd3;

   // label length classes
   localparam logic [7:0] LABEL_MAX_PLUS1 = 8'd64;
   localparam logic [7:0] POINTER_MIN     = 8'hC0;

   localparam logic [15:0] TYPE_A   = 16'd1;
   localparam logic [15:0] CLASS_IN = 16'd1;
   localparam logic [15:0] ONE_QUESTION = 16'd1;

   typedef struct packed {
      parse_phase_type phase;
      logic [3:0]      count;
      logic [15:0]     word_shift;
      logic [15:0]     txn_id;
      logic [15:0]     answers_left;
      logic [15:0]     skip_remaining;
      logic [15:0]     record_type;
      logic [31:0]     ttl;
      logic [31:0]     address;
      status_type      status;
   } parse_state_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] transaction_id;
      logic [31:0] address;
      logic [31:0] time_to_live;
   } result_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:          PH_HEADER,
      count:          4'd0,
      word_shift:     16'd0,
      txn_id:         16'd0,
      answers_left:   16'd0,
      skip_remaining: 16'd0,
      record_type:    16'd0,
      ttl:            32'd0,
      address:        32'd0,
      status:         ST_NOADDR
   };

endpackage

### hw/rtl/dnsp_if.sv
// ----------------------------------------------------------------------------
// dnsp channel interfaces
// valid/ready channels for packet bytes and parse results
// ----------------------------------------------------------------------------
interface dnsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] transaction_id;
   logic [31:0] address;
   logic [31:0] time_to_live;

   modport source (output valid, output status, output transaction_id,
                   output address, output time_to_live, input ready);
   modport sink   (input valid, input status, input transaction_id,
                   input address, input time_to_live, output ready);
endinterface

### hw/rtl/dnsp_parse_step.sv
// ----------------------------------------------------------------------------
// dnsp_parse_step
// next parse state and end-of-packet result for one packet byte
// ----------------------------------------------------------------------------
module dnsp_parse_step
   import dnsp_pkg::*;
(
   input  parse_state_type cur,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output parse_state_type nxt,
   output result_type      result
);

   parse_state_type upd;
   logic [15:0]     shift_new;
   logic [15:0]     skip_dec;
   logic [15:0]     ans_dec;
   status_type      st;

   always_comb begin
      upd       = cur;
      shift_new = {cur.word_shift[7:0], data_byte};
      skip_dec  = cur.skip_remaining - 16'd1;
      ans_dec   = cur.answers_left - 16'd1;

      if (cur.phase == PH_HEADER || cur.phase == PH_QTAIL || cur.phase == PH_AFIXED) begin
         upd.word_shift = shift_new;
      end

      case (cur.phase)
         PH_HEADER: begin
            if (cur.count == HDR_TXN_LO) upd.txn_id = shift_new;
            if (cur.count == HDR_FLAGS_LO && !shift_new[15]) upd.status = ST_NOTRESP;
            if (cur.count == HDR_QDCNT_LO && cur.status == ST_NOADDR &&
                shift_new != ONE_QUESTION) begin
               upd.status = ST_QCOUNT;
            end
            if (cur.count == HDR_ANCNT_LO) upd.answers_left = shift_new;
            if (cur.count >= HDR_LAST) begin
               upd.count = 4'd0;
               upd.phase = (cur.status != ST_NOADDR) ? PH_DONE : PH_QLEN;
            end else begin
               upd.count = cur.count + 4'd1;
            end
         end
         PH_QLEN: begin
            if (data_byte >= LABEL_MAX_PLUS1) begin
               upd.status = ST_BADNAME;
               upd.phase  = PH_DONE;
            end else if (data_byte == 8'd0) begin
               upd.phase = PH_QTAIL;
               upd.count = 4'd0;
            end else begin
               upd.skip_remaining = {8'd0, data_byte};
               upd.phase          = PH_QLABEL;
            end
         end
         PH_QLABEL: begin
            if (data_byte == 8'd0) begin
               upd.status = ST_BADNAME;
               upd.phase  = PH_DONE;
            end else begin
               upd.skip_remaining = skip_dec;
               if (skip_dec == 16'd0) upd.phase = PH_QLEN;
            end
         end
         PH_QTAIL: begin
            if (cur.count == QTAIL_TYPE_LO) upd.record_type = shift_new;
            if (cur.count >= QTAIL_LAST) begin
               upd.count = 4'd0;
               if (cur.record_type != TYPE_A || shift_new != CLASS_IN) begin
                  upd.status = ST_BADTC;
                  upd.phase  = PH_DONE;
               end else if (cur.answers_left == 16'd0) begin
                  upd.status = ST_NOADDR;
                  upd.phase  = PH_DONE;
               end else begin
                  upd.phase = PH_ALEN;
               end
            end else begin
               upd.count = cur.count + 4'd1;
            end
         end
         PH_ALEN: begin
            if (data_byte >= POINTER_MIN) begin
               upd.phase = PH_APTR;
            end else if (data_byte >= LABEL_MAX_PLUS1) begin
               upd.status = ST_NOADDR;
               upd.phase  = PH_DONE;
            end else if (data_byte == 8'd0) begin
               upd.phase = PH_AFIXED;
               upd.count = 4'd0;
            end else begin
               upd.skip_remaining = {8'd0, data_byte};
               upd.phase          = PH_ALABEL;
            end
         end
         PH_ALABEL: begin
            upd.skip_remaining = skip_dec;
            if (skip_dec == 16'd0) upd.phase = PH_ALEN;
         end
         PH_APTR: begin
            upd.phase = PH_AFIXED;
            upd.count = 4'd0;
         end
         PH_AFIXED: begin
            if (cur.count == AFIX_TYPE_LO) upd.record_type = shift_new;
            if (cur.count >= AFIX_TTL_FIRST && cur.count <= AFIX_TTL_LAST) begin
               upd.ttl = {cur.ttl[23:0], data_byte};
            end
            if (cur.count >= AFIX_LAST) begin
               upd.count          = 4'd0;
               upd.skip_remaining = shift_new;
               if (cur.record_type == TYPE_A) begin
                  upd.phase = PH_ADDR;
               end else if (shift_new == 16'd0) begin
                  // empty rdata: straight on to the next record, or done when none is left
                  upd.answers_left = ans_dec;
                  if (ans_dec == 16'd0) begin
                     upd.status = ST_NOADDR;
                     upd.phase  = PH_DONE;
                  end else begin
                     upd.phase = PH_ALEN;
                  end
               end else begin
                  upd.phase = PH_ASKIP;
               end
            end else begin
               upd.count = cur.count + 4'd1;
            end
         end
         PH_ADDR: begin
            upd.address = {cur.address[23:0], data_byte};
            if (cur.count >= ADDR_LAST) begin
               upd.count  = 4'd0;
               upd.status = ST_FOUND;
               upd.phase  = PH_DONE;
            end else begin
               upd.count = cur.count + 4'd1;
            end
         end
         PH_ASKIP: begin
            upd.skip_remaining = skip_dec;
            if (skip_dec == 16'd0) begin
               upd.answers_left = ans_dec;
               if (ans_dec == 16'd0) begin
                  upd.status = ST_NOADDR;
                  upd.phase  = PH_DONE;
               end else begin
                  upd.phase = PH_ALEN;
               end
            end
         end
         default: begin
         end
      endcase

      // status as seen at the end of the packet
      case (upd.phase)
         PH_HEADER: st = ST_SHORT;
         PH_QLEN:   st = ST_BADNAME;
         PH_QLABEL: st = ST_BADNAME;
         PH_QTAIL:  st = ST_BADTC;
         PH_DONE:   st = upd.status;
         default:   st = ST_NOADDR;
      endcase

      result.status         = st;
      result.transaction_id = (st == ST_SHORT) ? 16'd0 : upd.txn_id;
      result.address        = (st == ST_FOUND) ? upd.address : 32'd0;
      result.time_to_live   = (st == ST_FOUND) ? upd.ttl : 32'd0;

      nxt = last_byte ? PARSE_RESET : upd;
   end

endmodule

### hw/rtl/dns_response_a_record_parser.sv
// ----------------------------------------------------------------------------
// dns_response_a_record_parser
// byte-serial dns response checker that extracts the first a-record
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+---------------------------------------------
//  req_if  | in  | valid / ready   | data_byte[7:0], last_byte
//  rsp_if  | out | valid / ready   | status[2:0], transaction_id[15:0],
//          |     |                 | address[31:0], time_to_live[31:0]
//
//  one packet byte per clock sustained while no last byte waits for the result
//  slot; a byte is registered on entry and parsed from the input register,
//  and the result of the last byte is written into the result register
//  the throughput is set by the single parse step between the input and
//  output registers
//  reset (synchronous) returns the walk to the header phase and empties
//  both registers
//  a stalled result only holds the pipe when the next last byte arrives;
//  all other bytes keep flowing while the result waits
//
module dns_response_a_record_parser
   import dnsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dnsp_req_if.sink     req_if,
   dnsp_rsp_if.source   rsp_if
);

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff,  in_byte_in;
   logic            in_last_ff,  in_last_in;

   // parse state
   parse_state_type state_ff, state_in;
   parse_state_type state_step;

   // result register
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff,  out_data_in;
   result_type      step_result;

   logic            out_free;
   logic            proc_fire;
   logic            req_fire;

   dnsp_parse_step u_step (
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt       (state_step),
      .result    (step_result)
   );

   // a last byte may only be parsed when the result slot can take it
   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign proc_fire = in_valid_ff && (!in_last_ff || out_free);
   assign req_fire  = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || proc_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (proc_fire) in_valid_in = 1'b0;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
         in_last_in  = req_if.last_byte;
      end
   end

   assign state_in = proc_fire ? state_step : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_if.ready) out_valid_in = 1'b0;
      if (proc_fire && in_last_ff) begin
         out_valid_in = 1'b1;
         out_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.status         = out_data_ff.status;
   assign rsp_if.transaction_id = out_data_ff.transaction_id;
   assign rsp_if.address        = out_data_ff.address;
   assign rsp_if.time_to_live   = out_data_ff.time_to_live;

   // the walk restarts at the header after every packet end
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && in_last_ff) |=> (state_ff.phase == PH_HEADER && state_ff.count == 4'd0))
      else $error("parse state not restarted after last byte");

   // address and ttl are only reported with a found status
   a_found_only: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status != ST_FOUND) |->
         (out_data_ff.address == 32'd0 && out_data_ff.time_to_live == 32'd0))
      else $error("address reported without a found status");

   // a registered byte waiting for the result slot is kept
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc_fire) |=> (in_valid_ff && $stable(in_byte_ff)
                                       && $stable(in_last_ff)))
      else $error("pending packet byte lost");

   // the fixed-field byte counter never passes the header length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= HDR_LAST)
      else $error("field byte counter out of range");

endmodule
